// File: design/ffre_pkg.sv
package ffre_pkg;

   // Default frame store dimensions
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // Register port
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 9;

   localparam logic [CSR_AW-1:0] REG_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_AW-1:0] REG_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_AW-1:0] REG_TRANSFORM_MODE = 2'd2;

   localparam int SIZE_RESET = 256;

   // Transform modes
   localparam logic [1:0] MODE_FLIP_V   = 2'd0;
   localparam logic [1:0] MODE_FLIP_H   = 2'd1;
   localparam logic [1:0] MODE_ROT_CW   = 2'd2;
   localparam logic [1:0] MODE_ROT_CCW  = 2'd3;

   // Request kinds carried on tuser
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EMIT = 1'b1;

   // Pixel width
   localparam int PIX_W = 8;

   // Control from the top level to the emit sequencer
   typedef struct packed {
      logic clear;
      logic step;
   } ffre_ctl_type;

   // Clamp a size register to 1..max_v and return the last index (size - 1)
   function automatic int size_last(logic [CSR_DW-1:0] v, int max_v);
      int s;
      s = int'(v);
      if (s < 1) s = 1;
      if (s > max_v) s = max_v;
      return s - 1;
   endfunction

endpackage

// File: design/ffre_emit_seq.sv
module ffre_emit_seq
   import ffre_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_HEIGHT),
   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic          clock,
   input  logic          reset,
   input  ffre_ctl_type  ctl,
   input  logic [1:0]    mode,
   input  logic [CW-1:0] w_last,
   input  logic [RW-1:0] h_last,
   output logic [AW-1:0] rd_addr,
   output logic          frame_last
);

   localparam int PW = (CW > RW) ? CW : RW;

   logic [PW-1:0] row_ff, row_in;
   logic [PW-1:0] col_ff, col_in;
   logic [PW-1:0] rows_last, cols_last;
   logic [RW-1:0] src_row;
   logic [CW-1:0] src_col;
   logic          col_end, row_end;

   // Output frame shape: rotations swap rows and columns
   always_comb begin
      if (mode == MODE_ROT_CW || mode == MODE_ROT_CCW) begin
         rows_last = PW'(w_last);
         cols_last = PW'(h_last);
      end else begin
         rows_last = PW'(h_last);
         cols_last = PW'(w_last);
      end
   end

   assign col_end    = (col_ff == cols_last);
   assign row_end    = (row_ff == rows_last);
   assign frame_last = col_end && row_end;

   // Map output position to source position
   always_comb begin
      unique case (mode)
         MODE_FLIP_V: begin
            src_row = h_last - RW'(row_ff);
            src_col = CW'(col_ff);
         end
         MODE_FLIP_H: begin
            src_row = RW'(row_ff);
            src_col = w_last - CW'(col_ff);
         end
         MODE_ROT_CW: begin
            src_row = h_last - RW'(col_ff);
            src_col = CW'(row_ff);
         end
         MODE_ROT_CCW: begin
            src_row = RW'(col_ff);
            src_col = w_last - CW'(row_ff);
         end
         default: begin
            src_row = '0;
            src_col = '0;
         end
      endcase
   end

   assign rd_addr = AW'(src_row) * AW'(MAX_WIDTH) + AW'(src_col);

   // Advance in output raster order, wrap at the frame end
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (ctl.clear) begin
         row_in = '0;
         col_in = '0;
      end else if (ctl.step) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + PW'(1);
         end else begin
            col_in = col_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

// File: design/frame_flip_rotate_engine_unit.sv
// Frame store for 8-bit pixels that reads back flipped or rotated. A beat with
// req_tuser low loads req_tdata at the next source position in raster order; the
// position wraps after image_width * image_height loads. A beat with req_tuser
// high emits the next pixel of the transformed frame on rsp_tdata, with rsp_tlast
// on the final pixel of the output frame; mode 0 flips vertically, mode 1 flips
// horizontally, modes 2 and 3 rotate by 90 degrees and give image_width rows of
// image_height columns. Writes to the three registers reset both positions. Sizes
// of 0 read as 1 and sizes above MAX_WIDTH / MAX_HEIGHT saturate. Loads and emits
// are taken at one beat per clock unless the output stalls; an emitted pixel passes
// through the registered read of the single-port frame memory (MAX_WIDTH * MAX_HEIGHT
// bytes) and then the output register. The memory is not cleared: emit only pixels
// that were loaded.
module frame_flip_rotate_engine_unit
   import ffre_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   // Request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [PIX_W-1:0]  req_tdata,   // [7:0] pixel_in
   input  logic              req_tuser,   // [0] req_type
   // Result channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [PIX_W-1:0]  rsp_tdata,   // [7:0] pixel_out
   output logic              rsp_tlast,
   // Register write port
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   logic [CW-1:0]    w_last_ff;
   logic [RW-1:0]    h_last_ff;
   logic [1:0]       mode_ff;
   logic             cfg_hit;

   logic [RW-1:0]    load_row_ff;
   logic [CW-1:0]    load_col_ff;
   logic [AW-1:0]    wr_addr;

   logic [PIX_W-1:0] frame_mem [DEPTH];
   logic [PIX_W-1:0] mem_q_ff;
   logic             s1_vld_ff;
   logic             s1_last_ff;
   logic             rsp_vld_ff;
   logic [PIX_W-1:0] rsp_data_ff;
   logic             rsp_last_ff;

   logic             advance;
   logic             acc, acc_load, acc_emit;
   logic [AW-1:0]    rd_addr;
   logic             gen_last;
   ffre_ctl_type     emit_ctl;

   // Handshake: the read stage moves on whenever the output register frees up
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || advance;
   assign acc        = req_tvalid && req_tready;
   assign acc_load   = acc && (req_tuser == REQ_LOAD);
   assign acc_emit   = acc && (req_tuser == REQ_EMIT);

   assign cfg_hit = csr_we && (csr_index == REG_IMAGE_WIDTH ||
                               csr_index == REG_IMAGE_HEIGHT ||
                               csr_index == REG_TRANSFORM_MODE);

   // Configuration registers: sizes are held as clamped last indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= CW'(size_last(CSR_DW'(SIZE_RESET), MAX_WIDTH));
         h_last_ff <= RW'(size_last(CSR_DW'(SIZE_RESET), MAX_HEIGHT));
         mode_ff   <= MODE_FLIP_V;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:    w_last_ff <= CW'(size_last(csr_wdata, MAX_WIDTH));
            REG_IMAGE_HEIGHT:   h_last_ff <= RW'(size_last(csr_wdata, MAX_HEIGHT));
            REG_TRANSFORM_MODE: mode_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Load position in source raster order
   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         load_row_ff <= '0;
         load_col_ff <= '0;
      end else if (acc_load) begin
         if (load_col_ff == w_last_ff) begin
            load_col_ff <= '0;
            load_row_ff <= (load_row_ff == h_last_ff) ? '0 : load_row_ff + RW'(1);
         end else begin
            load_col_ff <= load_col_ff + CW'(1);
         end
      end
   end

   assign wr_addr = AW'(load_row_ff) * AW'(MAX_WIDTH) + AW'(load_col_ff);

   // Emit position and source address
   assign emit_ctl.clear = cfg_hit;
   assign emit_ctl.step  = acc_emit;

   ffre_emit_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_emit_seq (
      .clock      (clock),
      .reset      (reset),
      .ctl        (emit_ctl),
      .mode       (mode_ff),
      .w_last     (w_last_ff),
      .h_last     (h_last_ff),
      .rd_addr    (rd_addr),
      .frame_last (gen_last)
   );

   // Frame memory: write on load, registered read on emit
   always_ff @(posedge clock) begin
      if (acc_load) begin
         frame_mem[wr_addr] <= req_tdata;
      end
      if (acc_emit) begin
         mem_q_ff   <= frame_mem[rd_addr];
         s1_last_ff <= gen_last;
      end
   end

   // Read stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (acc_emit) begin
         s1_vld_ff <= 1'b1;
      end else if (advance) begin
         s1_vld_ff <= 1'b0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_vld_ff) begin
         rsp_data_ff <= mem_q_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: design/ffre_checker.sv
module ffre_checker
   import ffre_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [PIX_W-1:0]  rsp_tdata,
   input logic              rsp_tlast
);

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // No result comes out of reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A new result follows an emit beat through the read and output registers
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |->
         $past(req_tvalid && req_tready && (req_tuser == REQ_EMIT), 2))
      else $error("result without a matching emit beat");

   // Requests back up only behind a waiting result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled with free output");

endmodule

bind frame_flip_rotate_engine_unit ffre_checker u_ffre_checker (.*);
